FILE: hdl/greedy_word_wrap_macros.svh
`ifndef GREEDY_WORD_WRAP_MACROS_SVH
`define GREEDY_WORD_WRAP_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define GWW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define GWW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    `GWW_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: hdl/gww_pkg.sv
package gww_pkg;

    localparam int HOLD_DEPTH_DEFAULT = 64;
    localparam int CHAR_W             = 8;
    localparam int COL_W              = 7;
    localparam int WIDTH_W            = 6;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE     = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE       = 8'd32;
    localparam logic [COL_W-1:0]   COLUMN_MAX       = 7'd127;
    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = 6'd60;

    // register index taken from paddr[2]
    localparam logic REG_LINE_WIDTH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_EMIT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_held;
        logic load_direct;
        logic do_write;
    } dp_cmd_t;

    typedef struct packed {
        logic rel_now;
        logic direct_now;
        logic write_now;
        logic direct_pend;
        logic write_pend;
        logic rel_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/greedy_word_wrap.sv
// Greedy word wrap over a byte stream.
// Slave stream: one text byte per request in s_tdata, s_tlast marks end of text.
// Master stream: bytes in original order, some spaces rewritten as newline;
// m_tlast marks the final byte produced for one input request.
// Bytes from the most recent space onward are held in a RAM until the break
// point is known; with no pending space a byte passes straight through.
// APB port: register 0 (address 0) is line_width, 6 bits, reset 60.
// Sequence: a pass-through byte is accepted, then loaded into the output
// register; a byte that is held is accepted, then written to the RAM. Each
// released held byte takes a read and a load, set by the single registered
// RAM read port, so a new request is accepted only after all released bytes
// are loaded. A pass-through byte is loaded into the output in ST_EMIT.
// A finished result sits in the output register while the next request is
// accepted. When the receiver stalls, the output register holds and the
// controller waits; no data is dropped.
// Reset clears the count, pending space and column and sets the width to 60;
// the hold RAM is not cleared and needs no clearing pass.
module greedy_word_wrap #(
    parameter int HOLD_DEPTH = gww_pkg::HOLD_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // [7:0] char_in
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_out
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gww_pkg::dp_cmd_t    cmd;
    gww_pkg::dp_status_t status;

    assign pready = 1'b1;

    gww_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gww_datapath #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

FILE: hdl/gww_ram.sv
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/gww_ctrl.sv
module gww_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gww_pkg::dp_status_t status,
    output gww_pkg::dp_cmd_t    cmd
);

    gww_pkg::state_t state_reg;
    gww_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gww_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gww_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (status.rel_now)
                    begin
                        state_next = gww_pkg::ST_RD;
                    end
                    else if (status.direct_now)
                    begin
                        state_next = gww_pkg::ST_EMIT;
                    end
                    else if (status.write_now)
                    begin
                        state_next = gww_pkg::ST_WRITE;
                    end
                end
            end
            gww_pkg::ST_RD:
            begin
                state_next = gww_pkg::ST_WAIT;
            end
            gww_pkg::ST_WAIT:
            begin
                if (status.out_free)
                begin
                    if (!status.rel_last)
                    begin
                        state_next = gww_pkg::ST_RD;
                    end
                    else if (status.direct_pend)
                    begin
                        state_next = gww_pkg::ST_EMIT;
                    end
                    else if (status.write_pend)
                    begin
                        state_next = gww_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = gww_pkg::ST_IDLE;
                    end
                end
            end
            gww_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = gww_pkg::ST_IDLE;
                end
            end
            gww_pkg::ST_WRITE:
            begin
                state_next = gww_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gww_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            gww_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            gww_pkg::ST_RD:
            begin
                cmd.rd_issue = 1'b1;
            end
            gww_pkg::ST_WAIT:
            begin
                cmd.load_held = status.out_free;
            end
            gww_pkg::ST_EMIT:
            begin
                cmd.load_direct = status.out_free;
            end
            gww_pkg::ST_WRITE:
            begin
                cmd.do_write = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/gww_datapath.sv
`include "greedy_word_wrap_macros.svh"

module gww_datapath #(
    parameter int HOLD_DEPTH = gww_pkg::HOLD_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    // [7:0] char_in
    input  logic [7:0]          s_tdata,
    input  logic                s_tlast,
    // [7:0] char_out
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    input  gww_pkg::dp_cmd_t    cmd,
    output gww_pkg::dp_status_t status
);

    localparam int CNT_W = $clog2(HOLD_DEPTH);
    localparam logic [CNT_W-1:0] FULL_AT = CNT_W'(HOLD_DEPTH - 1);

    logic [gww_pkg::WIDTH_W-1:0] line_width_reg;
    logic [CNT_W-1:0]            held_count_reg, held_count_next;
    logic                        space_pending_reg, space_pending_next;
    logic [gww_pkg::COL_W-1:0]   column_reg, column_next;

    logic [CNT_W-1:0]            rel_count_reg, rel_idx_reg;
    logic                        rewrite_reg, direct_reg, write_reg;
    logic [gww_pkg::CHAR_W-1:0]  direct_val_reg, wr_data_reg;
    logic [CNT_W-1:0]            wr_addr_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [gww_pkg::CHAR_W-1:0]  out_data_reg;
    logic                        out_last_reg;

    logic                        rel_c, rew_c, direct_c, write_c;
    logic [gww_pkg::CHAR_W-1:0]  dval_c;
    logic [CNT_W-1:0]            waddr_c;
    logic [gww_pkg::COL_W-1:0]   col_inc;
    logic                        over_c, rel_last_c, out_free_c;
    logic [gww_pkg::CHAR_W-1:0]  ram_rdata;
    logic                        cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == gww_pkg::REG_LINE_WIDTH);
    assign prdata = (paddr[2] == gww_pkg::REG_LINE_WIDTH)
                  ? {26'd0, line_width_reg} : 32'd0;

    assign col_inc = (column_reg == gww_pkg::COLUMN_MAX)
                   ? gww_pkg::COLUMN_MAX : column_reg + 7'd1;
    assign over_c  = column_reg > {1'b0, line_width_reg};

    // per-item decision: release held, then emit direct byte or store it
    always_comb
    begin
        rel_c              = 1'b0;
        rew_c              = 1'b0;
        direct_c           = 1'b1;
        write_c            = 1'b0;
        dval_c             = s_tdata;
        waddr_c            = '0;
        held_count_next    = held_count_reg;
        space_pending_next = space_pending_reg;
        column_next        = col_inc;
        if (s_tdata == gww_pkg::NEWLINE_CODE)
        begin
            rel_c              = held_count_reg != '0;
            held_count_next    = '0;
            space_pending_next = 1'b0;
            column_next        = '0;
        end
        else if (s_tdata == gww_pkg::SPACE_CODE)
        begin
            rel_c = space_pending_reg && (held_count_reg != '0);
            if (over_c)
            begin
                dval_c             = gww_pkg::NEWLINE_CODE;
                held_count_next    = '0;
                space_pending_next = 1'b0;
                column_next        = '0;
            end
            else
            begin
                direct_c           = 1'b0;
                write_c            = 1'b1;
                held_count_next    = CNT_W'(1);
                space_pending_next = 1'b1;
            end
        end
        else if (space_pending_reg)
        begin
            if (over_c)
            begin
                rel_c              = held_count_reg != '0;
                rew_c              = 1'b1;
                held_count_next    = '0;
                space_pending_next = 1'b0;
                column_next        = gww_pkg::COL_W'(held_count_reg);
            end
            else if (held_count_reg >= FULL_AT)
            begin
                rel_c              = 1'b1;
                held_count_next    = '0;
                space_pending_next = 1'b0;
            end
            else
            begin
                direct_c        = 1'b0;
                write_c         = 1'b1;
                waddr_c         = held_count_reg;
                held_count_next = held_count_reg + CNT_W'(1);
            end
        end
        if (s_tlast)
        begin
            // end of text: stored byte goes out directly after the release
            if (write_c)
            begin
                rel_c    = held_count_reg != '0;
                write_c  = 1'b0;
                direct_c = 1'b1;
            end
            held_count_next    = '0;
            space_pending_next = 1'b0;
            column_next        = '0;
        end
    end

    assign rel_last_c = rel_idx_reg == (rel_count_reg - CNT_W'(1));
    assign out_free_c = !out_valid_reg || m_tready;

    always_comb
    begin
        status.rel_now     = rel_c;
        status.direct_now  = direct_c;
        status.write_now   = write_c;
        status.direct_pend = direct_reg;
        status.write_pend  = write_reg;
        status.rel_last    = rel_last_c;
        status.out_free    = out_free_c;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_held || cmd.load_direct)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg    <= gww_pkg::LINE_WIDTH_RESET;
            held_count_reg    <= '0;
            space_pending_reg <= 1'b0;
            column_reg        <= '0;
            out_valid_reg     <= 1'b0;
            direct_reg        <= 1'b0;
            write_reg         <= 1'b0;
            rel_idx_reg       <= '0;
            rel_count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
            begin
                line_width_reg <= pwdata[gww_pkg::WIDTH_W-1:0];
            end
            if (cmd.accept)
            begin
                held_count_reg    <= held_count_next;
                space_pending_reg <= space_pending_next;
                column_reg        <= column_next;
                direct_reg        <= direct_c;
                write_reg         <= write_c;
                rel_count_reg     <= held_count_reg;
                rel_idx_reg       <= '0;
            end
            else if (cmd.load_held)
            begin
                rel_idx_reg <= rel_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rewrite_reg    <= rew_c;
            direct_val_reg <= dval_c;
            wr_addr_reg    <= waddr_c;
            wr_data_reg    <= s_tdata;
        end
        if (cmd.load_held)
        begin
            out_data_reg <= (rewrite_reg && (rel_idx_reg == '0))
                          ? gww_pkg::NEWLINE_CODE : ram_rdata;
            out_last_reg <= rel_last_c && !direct_reg;
        end
        else if (cmd.load_direct)
        begin
            out_data_reg <= direct_val_reg;
            out_last_reg <= 1'b1;
        end
    end

    gww_ram #(
        .WIDTH (gww_pkg::CHAR_W),
        .DEPTH (HOLD_DEPTH)
    ) u_hold (
        .clk   (clk),
        .we    (cmd.do_write),
        .waddr (wr_addr_reg),
        .wdata (wr_data_reg),
        .re    (cmd.rd_issue),
        .raddr (rel_idx_reg),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `GWW_ASSERT_IMPLY(a_held_needs_space, held_count_reg != '0, space_pending_reg,
                      "held bytes without a pending space")
    `GWW_ASSERT_IMPLY(a_rel_in_range, cmd.load_held, rel_idx_reg < rel_count_reg,
                      "release index past held count")
    `GWW_ASSERT_IMPLY(a_load_when_free, cmd.load_held || cmd.load_direct, out_free_c,
                      "output register overwritten")
    `GWW_ASSERT(a_count_bound, held_count_reg <= FULL_AT, "held count above limit")

endmodule

FILE: sim/gww_wrap_checker.sv
module gww_wrap_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending_results,
    output int          fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_LIMIT = gww_pkg::HOLD_DEPTH_DEFAULT;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } wrap_byte_t;

    logic [7:0]   held_text [HOLD_LIMIT];
    int unsigned  held_len      = 0;
    logic         space_held    = 1'b0;
    logic [6:0]   column        = '0;
    logic [5:0]   wrap_width    = gww_pkg::LINE_WIDTH_RESET;
    logic [7:0]   step_bytes [$];
    wrap_byte_t   expected_bytes [$];
    int           mismatches    = 0;

    function automatic logic [6:0] bump_column(input logic [6:0] c);
        return (c == gww_pkg::COLUMN_MAX) ? gww_pkg::COLUMN_MAX : c + 7'd1;
    endfunction

    function void release_held(input bit as_break);
        for (int i = 0; i < held_len; i++)
            step_bytes.push_back((i == 0 && as_break) ? gww_pkg::NEWLINE_CODE
                                                      : held_text[i]);
        held_len = 0;
    endfunction

    function void predict_wrap(input logic [7:0] ch, input logic eot);
        logic [6:0]  cur;
        int unsigned after;
        cur = column;
        if (ch == gww_pkg::NEWLINE_CODE)
        begin
            release_held(1'b0);
            step_bytes.push_back(ch);
            space_held = 1'b0;
            column     = '0;
        end
        else if (ch == gww_pkg::SPACE_CODE)
        begin
            if (space_held)
                release_held(1'b0);
            held_text[0] = ch;
            held_len     = 1;
            space_held   = 1'b1;
            if (cur > wrap_width)
            begin
                release_held(1'b1);
                space_held = 1'b0;
                column     = '0;
            end
            else
                column = bump_column(cur);
        end
        else if (space_held)
        begin
            if (cur > wrap_width)
            begin
                after = held_len;
                release_held(1'b1);
                step_bytes.push_back(ch);
                space_held = 1'b0;
                column     = (after > gww_pkg::COLUMN_MAX) ? gww_pkg::COLUMN_MAX
                                                           : after[6:0];
            end
            else if (held_len >= HOLD_LIMIT - 1)
            begin
                // store full: give up the break
                release_held(1'b0);
                step_bytes.push_back(ch);
                space_held = 1'b0;
                column     = bump_column(cur);
            end
            else
            begin
                held_text[held_len] = ch;
                held_len++;
                column = bump_column(cur);
            end
        end
        else
        begin
            step_bytes.push_back(ch);
            column = bump_column(cur);
        end

        if (eot)
        begin
            release_held(1'b0);
            space_held = 1'b0;
            column     = '0;
        end

        foreach (step_bytes[i])
            expected_bytes.push_back('{step_bytes[i], i == step_bytes.size() - 1});
        step_bytes.delete();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wrap_byte_t got;
        wrap_byte_t want;
        if (!rst_n)
        begin
            held_len   = 0;
            space_held = 1'b0;
            column     = '0;
            wrap_width = gww_pkg::LINE_WIDTH_RESET;
            expected_bytes.delete();
            pending_results <= 0;
            fail_count      <= mismatches;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == gww_pkg::REG_LINE_WIDTH)
                wrap_width = pwdata[5:0];
            if (s_tvalid && s_tready)
                predict_wrap(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata, m_tlast};
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected byte %02h last %b", $realtime,
                                 m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: byte exp %02h last %b, got %02h last %b",
                                     $realtime, want.ch, want.last, got.ch, got.last);
                    end
                end
            end
            pending_results <= expected_bytes.size();
            fail_count      <= mismatches;
        end
    end

endmodule

FILE: sim/tb_greedy_word_wrap.sv
module tb_greedy_word_wrap;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int   pending_results;
    int   fail_count;
    logic quiet     = 1'b0;
    int   stall_req = 0;

    always #5 clk = ~clk;

    greedy_word_wrap u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gww_wrap_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .pending_results (pending_results),
        .fail_count      (fail_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // any byte except space and newline
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == gww_pkg::NEWLINE_CODE || b == gww_pkg::SPACE_CODE);
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= ch;
        s_tlast  <= eot;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_letters(input int n);
        repeat (n) send_byte(pick_text_byte(), 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_width(input logic [5:0] w);
        wait_drained();
        // a held byte may still be going into the store
        repeat (20) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {gww_pkg::REG_LINE_WIDTH, 2'b00};
        pwdata  <= {26'($urandom_range(0, 32'h03FF_FFFF)), w};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // words with random content, spaces and newlines, some noise
    task automatic send_random_text(input int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
                                                   : $urandom_range(1, 12);
                send_letters(len);
                sent += len;
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_byte(gww_pkg::SPACE_CODE, 1'b0);
                else if (r < 80)
                begin
                    send_byte(gww_pkg::SPACE_CODE, 1'b0);
                    send_byte(gww_pkg::SPACE_CODE, 1'b0);
                    sent++;
                end
                else if (r < 92)
                    send_byte(gww_pkg::NEWLINE_CODE, 1'b0);
                else
                    send_byte(gww_pkg::SPACE_CODE, 1'b1);
                sent++;
            end
        end
    endtask

    // receiver
    initial
    begin
        int stall_done;
        int g;
        stall_done = 0;
        forever
        begin
            if (stall_req != stall_done)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                stall_done++;
            end
            else
            begin
                g = pick_gap();
                if (g == 0)
                begin
                    m_tready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    m_tready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("[greedy_word_wrap] ERROR");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: break, double space, newline, space past width, end with space held
        write_width(6'd4);
        send_text("ab cde f  gh");
        send_byte(gww_pkg::NEWLINE_CODE, 1'b0);
        send_text("abcdef ");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(" x");
        send_byte(8'hA5, 1'b1);

        write_width(6'd1);
        send_random_text(10);
        write_width(6'd0);
        send_random_text(8);

        // full store
        write_width(6'd63);
        send_byte(gww_pkg::NEWLINE_CODE, 1'b0);
        send_byte(gww_pkg::SPACE_CODE, 1'b0);
        send_letters(64);
        send_byte(gww_pkg::SPACE_CODE, 1'b0);
        send_text("ab");
        send_byte(pick_text_byte(), 1'b1);

        // long receiver stall against pass-through bytes
        wait_drained();
        quiet     <= 1'b1;
        stall_req <= stall_req + 1;
        send_byte(gww_pkg::NEWLINE_CODE, 1'b0);
        send_letters(16);
        wait_drained();
        quiet <= 1'b0;

        write_width(6'($urandom_range(2, 20)));
        send_random_text(12);
        write_width(6'($urandom_range(0, 63)));
        send_random_text(10);

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("[greedy_word_wrap] OK");
        else
            $display("[greedy_word_wrap] ERROR");
        $finish;
    end

endmodule

FILE: greedy_word_wrap.f
+incdir+hdl
hdl/gww_pkg.sv
hdl/gww_ram.sv
hdl/gww_ctrl.sv
hdl/gww_datapath.sv
hdl/greedy_word_wrap.sv
sim/gww_wrap_checker.sv
sim/tb_greedy_word_wrap.sv
